/* sv/near_work_dwell_and_light_monitor_macros.svh */
// assertion macros for the near-work dwell and light monitor
// used by the checker file, relies on clk_i and rst_ni being in scope
`ifndef NEAR_WORK_DWELL_AND_LIGHT_MONITOR_MACROS_SVH
`define NEAR_WORK_DWELL_AND_LIGHT_MONITOR_MACROS_SVH

// clocked property, switched off while reset is held
`define NWDL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nwdl assertion failed");

// clocked property that is also checked while reset is held
`define NWDL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("nwdl assertion failed");

`endif

/* sv/nwdl_pkg.sv */
// shared types, register codes and constant-divide helpers for the monitor
// no dependencies; used by every module of the block
package nwdl_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNearLimit  = 3'd0,
    CfgDwell      = 3'd1,
    CfgBreakLimit = 3'd2,
    CfgLuxAdequate = 3'd3,
    CfgLuxGood    = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] NearLimitRst   = 16'd300;
  localparam logic [15:0] DwellRst       = 16'd300;
  localparam logic [15:0] BreakLimitRst  = 16'd1000;
  localparam logic [15:0] LuxAdequateRst = 16'd300;
  localparam logic [15:0] LuxGoodRst     = 16'd500;

  localparam logic [1:0] LightLow      = 2'd0;
  localparam logic [1:0] LightAdequate = 2'd1;
  localparam logic [1:0] LightGood     = 2'd2;

  localparam logic [7:0] DoseMax = 8'd255;

  // reciprocals for the constant divides
  localparam logic [16:0] BlueRecip = 17'd67109;       // 2^26 / 1000, rounded up
  localparam logic [21:0] PctRecip  = 22'd3289700;     // 100 * (2^23 / 255, rounded up)
  localparam logic [31:0] MinRecip  = 32'h8888_8889;   // 2^35 / 15, rounded up

  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] lux;
    logic [15:0] blue_power;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic [1:0]  light_quality;
    logic [7:0]  dose;
    logic [6:0]  dose_percent;
    logic        near_active;
    logic [26:0] near_minutes;
  } out_t;

  // what the first stage hands to the result stage
  typedef struct packed {
    logic [1:0]  light_quality;
    logic [7:0]  dose;
    logic        near_active;
    logic        recalc;
    logic [31:0] elapsed;
  } stage_t;

  // blue_power / 1000
  function automatic logic [6:0] blue_to_dose(input logic [15:0] b);
    logic [32:0] p;
    p = 33'(b) * 33'(BlueRecip);
    return p[32:26];
  endfunction

  // dose * 100 / 255
  function automatic logic [6:0] dose_to_pct(input logic [7:0] d);
    logic [29:0] p;
    p = 30'(d) * 30'(PctRecip);
    return p[29:23];
  endfunction

  // seconds / 60, done as (seconds / 4) / 15
  function automatic logic [26:0] secs_to_min(input logic [31:0] s);
    logic [61:0] p;
    p = 62'(s[31:2]) * 62'(MinRecip);
    return p[61:35];
  endfunction

endpackage

/* sv/nwdl_out_stage.sv */
// result stage: minute and percentage conversion plus the output register
// depends on nwdl_pkg
module nwdl_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s1_valid_i,
  input  nwdl_pkg::stage_t s1_i,
  output logic            adv_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nwdl_pkg::out_t  out_o
);

  logic           out_valid_q;
  nwdl_pkg::out_t out_q, out_d;

  assign adv_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.light_quality = s1_i.light_quality;
    out_d.dose          = s1_i.dose;
    out_d.dose_percent  = nwdl_pkg::dose_to_pct(s1_i.dose);
    out_d.near_active   = s1_i.near_active;
    // minutes hold their last value unless this request refreshed them
    out_d.near_minutes  = s1_i.recalc ? nwdl_pkg::secs_to_min(s1_i.elapsed)
                                      : out_q.near_minutes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (adv_o) begin
      out_valid_q <= s1_valid_i;
      if (s1_valid_i) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* sv/near_work_dwell_and_light_monitor.sv */
// a taken request is registered in stage one and then in the output register of the
// result stage, which drives out_o
// throughput: one request per cycle; a held result stalls both stages, two requests deep
// reset (rst_ni low, asynchronous): registers go to their defaults, dose,
// timers and session state clear, both pipeline stages empty
// the feedback path (dose, arm and session state) closes within stage one
module near_work_dwell_and_light_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  nwdl_pkg::in_t                   in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output nwdl_pkg::out_t                  out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nwdl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [nwdl_pkg::CfgDataW-1:0]   cfg_data_i
);

  // ---------------------------------------------------------------
  // configuration registers, always writable
  // ---------------------------------------------------------------
  logic [15:0] near_limit_q, dwell_q, break_limit_q, lux_adequate_q, lux_good_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_limit_q   <= nwdl_pkg::NearLimitRst;
      dwell_q        <= nwdl_pkg::DwellRst;
      break_limit_q  <= nwdl_pkg::BreakLimitRst;
      lux_adequate_q <= nwdl_pkg::LuxAdequateRst;
      lux_good_q     <= nwdl_pkg::LuxGoodRst;
    end else if (cfg_valid_i) begin
      // indexes past the list are dropped
      unique case (cfg_index_i)
        nwdl_pkg::CfgNearLimit:   near_limit_q   <= cfg_data_i;
        nwdl_pkg::CfgDwell:       dwell_q        <= cfg_data_i;
        nwdl_pkg::CfgBreakLimit:  break_limit_q  <= cfg_data_i;
        nwdl_pkg::CfgLuxAdequate: lux_adequate_q <= cfg_data_i;
        nwdl_pkg::CfgLuxGood:     lux_good_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // flow control: stage one moves when empty or when the result
  // stage takes its contents
  // ---------------------------------------------------------------
  logic s1_valid_q;
  logic out_adv;
  logic in_acc;

  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------
  // tracking state
  // ---------------------------------------------------------------
  logic        armed_q, armed_d;
  logic [31:0] close_since_q, close_since_d;
  logic        session_on_q, session_on_d;
  logic [31:0] session_start_q, session_start_d;
  logic [7:0]  dose_total_q, dose_total_d;

  // per-request decisions
  logic        is_close;
  logic        is_far;
  logic [31:0] close_elapsed;
  logic        dwell_met;
  logic        starting;
  logic [8:0]  dose_sum;
  logic [1:0]  quality;
  nwdl_pkg::stage_t s1_q, s1_d;

  always_comb begin
    // light grading: adequate test first, so a good limit set below the
    // adequate limit still leaves the gap graded as low
    if (in_i.lux < lux_adequate_q) begin
      quality = nwdl_pkg::LightLow;
    end else if (in_i.lux < lux_good_q) begin
      quality = nwdl_pkg::LightAdequate;
    end else begin
      quality = nwdl_pkg::LightGood;
    end

    // saturating dose, widened by a bit so the add cannot wrap
    dose_sum     = {1'b0, dose_total_q} + 9'(nwdl_pkg::blue_to_dose(in_i.blue_power));
    dose_total_d = (dose_sum > 9'(nwdl_pkg::DoseMax)) ? nwdl_pkg::DoseMax : dose_sum[7:0];

    // a zero distance is no reading, never close
    is_close      = (in_i.distance != 16'd0) && (in_i.distance < near_limit_q);
    is_far        = in_i.distance > break_limit_q;
    // elapsed times are modulo 2^32, a backwards clock reads as long
    close_elapsed = in_i.now_seconds - close_since_q;
    // the first close sample only arms, so the dwell test needs armed
    dwell_met     = armed_q && (close_elapsed > 32'(dwell_q));
    starting      = is_close && dwell_met && !session_on_q;

    armed_d         = is_close;
    close_since_d   = (is_close && !armed_q) ? in_i.now_seconds : close_since_q;
    session_start_d = starting ? in_i.now_seconds : session_start_q;
    if (is_close) begin
      session_on_d = session_on_q || dwell_met;
    end else begin
      // only a far reading ends a session, a middle distance keeps it
      session_on_d = session_on_q && !is_far;
    end

    s1_d.light_quality = quality;
    s1_d.dose          = dose_total_d;
    s1_d.near_active   = session_on_d;
    // minutes refresh on every close sample past the dwell
    s1_d.recalc        = is_close && dwell_met;
    s1_d.elapsed       = starting ? 32'd0 : (in_i.now_seconds - session_start_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q         <= 1'b0;
      close_since_q   <= '0;
      session_on_q    <= 1'b0;
      session_start_q <= '0;
      dose_total_q    <= '0;
    end else if (in_acc) begin
      armed_q         <= armed_d;
      close_since_q   <= close_since_d;
      session_on_q    <= session_on_d;
      session_start_q <= session_start_d;
      dose_total_q    <= dose_total_d;
    end
  end

  // stage one register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------
  // result stage: divide-by-60 and percentage, then output register
  // ---------------------------------------------------------------
  nwdl_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .s1_i        (s1_q),
    .adv_o       (out_adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

/* sv/nwdl_checker.sv */
// port-level checker for the monitor, attached by the bind at the end
// depends on nwdl_pkg and the macro header
`include "near_work_dwell_and_light_monitor_macros.svh"

module nwdl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input nwdl_pkg::out_t out_o
);

  // a stalled result holds
  `NWDL_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))

  // full dose and a hundred percent go together
  `NWDL_ASSERT(a_pct_full, out_valid_o |-> ((out_o.dose == nwdl_pkg::DoseMax) == (out_o.dose_percent == 7'd100)))

  // no fourth light grade
  `NWDL_ASSERT(a_grade_range, out_valid_o |-> out_o.light_quality <= nwdl_pkg::LightGood)

  // an empty result register never holds back a request
  `NWDL_ASSERT(a_empty_ready, !out_valid_o |-> in_ready_o)

  // nothing comes out straight after reset
  `NWDL_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o)

endmodule

bind near_work_dwell_and_light_monitor nwdl_checker u_nwdl_checker (.*);

/* tb/sv/tb_near_work_dwell_and_light_monitor.sv */
// self-checking testbench for the near-work dwell and light monitor
// depends on nwdl_pkg and near_work_dwell_and_light_monitor; needs nothing else
`timescale 1ns / 1ps

module tb_near_work_dwell_and_light_monitor;

  // fixed figures of the monitor's arithmetic
  localparam int unsigned MilliPerDose = 1000;
  localparam int unsigned SecPerMin    = 60;
  localparam int unsigned PercentFull  = 100;

  // run shape
  localparam int unsigned PhaseItems = 80;   // random requests per register setting
  localparam int unsigned HoldAt     = 150;  // reading count at which the long hold starts
  localparam int unsigned HoldCycles = 60;   // length of that hold
  localparam int unsigned StallLimit = 1000; // quiet cycles before the run is abandoned
  localparam int unsigned DrainCycles = 8;   // settle time after the last reading

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  nwdl_pkg::in_t   in_i;
  logic  out_valid_o;
  logic  out_ready_i;
  nwdl_pkg::out_t  out_o;
  logic  cfg_valid_i;
  logic  cfg_ready_o;
  logic [nwdl_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [nwdl_pkg::CfgDataW-1:0] cfg_data_i;

  near_work_dwell_and_light_monitor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // own copy of the monitor: thresholds, then dwell, session and dose state
  logic [15:0] near_mm, dwell_s, break_mm, lux_ok, lux_fine;
  logic        armed_q, session_q;
  logic [31:0] close_t, session_t;
  logic [26:0] minutes_q;
  logic [7:0]  dose_q;

  // readings still owed by the block, oldest first
  nwdl_pkg::out_t readings_due [$];
  int unsigned readings_taken = 0;
  int unsigned faults = 0;

  // idle bookkeeping for both sides
  int unsigned rx_wait = 0;
  int unsigned calm_tx = 0;
  int unsigned calm_rx = 0;

  // random walk of the sensor: wall clock and whether the user is leaning in
  logic [31:0] wall_s = '0;
  bit          near_run = 1'b0;

  // directed requests, with a typed reading where it is plain to see
  typedef struct packed {
    nwdl_pkg::in_t  smp;
    bit             pinned;
    nwdl_pkg::out_t want;
  } probe_t;
  probe_t probes [$];

  nwdl_pkg::cfg_idx_e reg_order [5];
  logic [15:0] plan [5][5];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string msg);
    faults++;
    $display("[%0t] %s", $time, msg);
  endtask

  // idle cycles before the next request; now and then a calm stretch with none
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, 12);
  endfunction

  // one sample through the monitor: grade the light, add the dose, track near work
  function automatic nwdl_pkg::out_t predict_reading(input nwdl_pkg::in_t s);
    nwdl_pkg::out_t r;
    logic        close;
    int unsigned sum;
    logic [31:0] span;
    // adequate is tested first, so an inverted pair leaves the gap as insufficient
    if (s.lux < lux_ok) begin
      r.light_quality = nwdl_pkg::LightLow;
    end else if (s.lux < lux_fine) begin
      r.light_quality = nwdl_pkg::LightAdequate;
    end else begin
      r.light_quality = nwdl_pkg::LightGood;
    end
    // dose clamps at full scale and never wraps
    sum = dose_q + s.blue_power / MilliPerDose;
    dose_q = (sum > nwdl_pkg::DoseMax) ? nwdl_pkg::DoseMax : sum[7:0];
    close = (s.distance != '0) && (s.distance < near_mm);
    if (close) begin
      if (!armed_q) begin
        // first close sample only starts the dwell timer
        armed_q = 1'b1;
        close_t = s.now_seconds;
      end else begin
        // elapsed times wrap modulo 2^32, so a clock going back looks long
        span = s.now_seconds - close_t;
        if (span > {16'b0, dwell_s}) begin
          if (!session_q) begin
            session_q = 1'b1;
            session_t = s.now_seconds;
          end
          span = s.now_seconds - session_t;
          minutes_q = 27'(span / SecPerMin);
        end
      end
    end else begin
      // leaving the near band disarms; only a far reading ends the session
      if (session_q && (s.distance > break_mm)) session_q = 1'b0;
      armed_q = 1'b0;
    end
    r.dose         = dose_q;
    r.dose_percent = 7'((32'(dose_q) * PercentFull) / nwdl_pkg::DoseMax);
    r.near_active  = session_q;
    r.near_minutes = minutes_q;
    return r;
  endfunction

  function automatic void add_probe(input logic [15:0] d, l, b, input logic [31:0] t,
                                    input bit pinned = 1'b0,
                                    input nwdl_pkg::out_t want = '0);
    probe_t p;
    p.smp    = '{distance: d, lux: l, blue_power: b, now_seconds: t};
    p.pinned = pinned;
    p.want   = want;
    probes.push_back(p);
  endfunction

  // mostly runs of close samples with a creeping clock, plus noise and clock jumps
  function automatic nwdl_pkg::in_t draft_sample();
    nwdl_pkg::in_t s;
    int unsigned pick;
    if ($urandom_range(0, 24) == 0) begin
      wall_s = $urandom();
    end else begin
      wall_s = wall_s + $urandom_range(0, 4);
    end
    if ($urandom_range(0, 7) == 0) near_run = !near_run;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      s.distance = 16'($urandom());
    end else if (pick == 1) begin
      s.distance = '0;
    end else if (near_run && (near_mm > 16'd1)) begin
      s.distance = 16'($urandom_range(1, int'(near_mm) - 1));
    end else if ((pick < 6) && (break_mm != 16'hFFFF)) begin
      s.distance = 16'($urandom_range(int'(break_mm) + 1, 16'hFFFF));
    end else begin
      // between the two limits: neither close nor far enough for a break
      s.distance = 16'($urandom_range(int'(near_mm), int'(break_mm)));
    end
    case ($urandom_range(0, 4))
      0: begin
        s.lux = lux_ok - 16'($urandom_range(0, 1));
      end
      1: begin
        s.lux = lux_fine - 16'($urandom_range(0, 1));
      end
      default: begin
        s.lux = 16'($urandom());
      end
    endcase
    s.blue_power  = 16'($urandom());
    s.now_seconds = wall_s;
    return s;
  endfunction

  // present one request; valid is only dropped when a gap is drawn
  task automatic offer_sample(input nwdl_pkg::in_t s, input bit pinned = 1'b0,
                              input nwdl_pkg::out_t want = '0);
    int unsigned    gap;
    nwdl_pkg::out_t guess;
    gap = draw_gap(calm_tx);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= s;
    do @(posedge clk_i); while (!in_ready_o);
    guess = predict_reading(s);
    readings_due.push_back(pinned ? want : guess);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input nwdl_pkg::cfg_idx_e idx, input logic [15:0] val);
    int unsigned gap;
    gap = draw_gap(calm_tx);
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      nwdl_pkg::CfgNearLimit: begin
        near_mm = val;
      end
      nwdl_pkg::CfgDwell: begin
        dwell_s = val;
      end
      nwdl_pkg::CfgBreakLimit: begin
        break_mm = val;
      end
      nwdl_pkg::CfgLuxAdequate: begin
        lux_ok = val;
      end
      nwdl_pkg::CfgLuxGood: begin
        lux_fine = val;
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  // stimulus: directed table under reset thresholds, then random phases
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = nwdl_pkg::CfgNearLimit;
    cfg_data_i  = '0;

    near_mm   = nwdl_pkg::NearLimitRst;
    dwell_s   = nwdl_pkg::DwellRst;
    break_mm  = nwdl_pkg::BreakLimitRst;
    lux_ok    = nwdl_pkg::LuxAdequateRst;
    lux_fine  = nwdl_pkg::LuxGoodRst;
    armed_q   = 1'b0;
    session_q = 1'b0;
    close_t   = '0;
    session_t = '0;
    minutes_q = '0;
    dose_q    = '0;

    // all zero straight after reset, then every field at its top
    add_probe(16'd0, 16'd0, 16'd0, 32'd0, 1'b1,
              nwdl_pkg::out_t'{nwdl_pkg::LightLow, 8'd0, 7'd0, 1'b0, 27'd0});
    add_probe(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
              nwdl_pkg::out_t'{nwdl_pkg::LightGood, 8'd65, 7'd25, 1'b0, 27'd0});
    // light grading on either side of each threshold, dose steps of one
    add_probe(16'd0, 16'd299, 16'd999, 32'd1, 1'b1,
              nwdl_pkg::out_t'{nwdl_pkg::LightLow, 8'd65, 7'd25, 1'b0, 27'd0});
    add_probe(16'd0, 16'd300, 16'd1000, 32'd2, 1'b1,
              nwdl_pkg::out_t'{nwdl_pkg::LightAdequate, 8'd66, 7'd25, 1'b0, 27'd0});
    add_probe(16'd0, 16'd499, 16'd0, 32'd3, 1'b1,
              nwdl_pkg::out_t'{nwdl_pkg::LightAdequate, 8'd66, 7'd25, 1'b0, 27'd0});
    add_probe(16'd0, 16'd500, 16'd1999, 32'd4, 1'b1,
              nwdl_pkg::out_t'{nwdl_pkg::LightGood, 8'd67, 7'd26, 1'b0, 27'd0});
    // arm, dwell exactly met (no session), dwell exceeded, minutes count up
    add_probe(16'd1, 16'd400, 16'd0, 32'd1000);
    add_probe(16'd299, 16'd400, 16'd0, 32'd1300);
    add_probe(16'd150, 16'd400, 16'd0, 32'd1301);
    add_probe(16'd150, 16'd400, 16'd0, 32'd1426);
    // near limit itself and the break limit itself keep the session
    add_probe(16'd300, 16'd400, 16'd0, 32'd1500);
    add_probe(16'd1000, 16'd400, 16'd0, 32'd1501);
    // re-arm inside a running session, minutes recomputed, then break past the limit
    add_probe(16'd100, 16'd400, 16'd0, 32'd1502);
    add_probe(16'd100, 16'd400, 16'd0, 32'd1900);
    add_probe(16'd1001, 16'd400, 16'd0, 32'd1901);
    // clock running backwards reads as a very long dwell and session
    add_probe(16'd100, 16'd400, 16'd0, 32'd5000);
    add_probe(16'd100, 16'd400, 16'd0, 32'd3000);
    add_probe(16'd100, 16'd400, 16'd0, 32'd2999);
    // no valid reading: disarms but leaves the session alone
    add_probe(16'd0, 16'd400, 16'd0, 32'd3000);
    // dose runs into its ceiling
    add_probe(16'd2000, 16'hFFFF, 16'hFFFF, 32'd3001);
    add_probe(16'd2000, 16'hFFFF, 16'hFFFF, 32'd3002);
    add_probe(16'd2000, 16'hFFFF, 16'hFFFF, 32'd3003, 1'b1,
              nwdl_pkg::out_t'{nwdl_pkg::LightGood, 8'd255, 7'd100, 1'b0, 27'd71582788});
    add_probe(16'hFFFE, 16'd0, 16'hFFFF, 32'd0, 1'b1,
              nwdl_pkg::out_t'{nwdl_pkg::LightLow, 8'd255, 7'd100, 1'b0, 27'd71582788});

    reg_order = '{nwdl_pkg::CfgNearLimit, nwdl_pkg::CfgDwell, nwdl_pkg::CfgBreakLimit,
                  nwdl_pkg::CfgLuxAdequate, nwdl_pkg::CfgLuxGood};
    // everyday settings with a short dwell so sessions come and go
    foreach (plan[p]) begin
      plan[p][nwdl_pkg::CfgNearLimit]   = 16'($urandom_range(50, 3000));
      plan[p][nwdl_pkg::CfgDwell]       = 16'($urandom_range(0, 20));
      plan[p][nwdl_pkg::CfgBreakLimit]  = plan[p][nwdl_pkg::CfgNearLimit] +
                                          16'($urandom_range(0, 2000));
      plan[p][nwdl_pkg::CfgLuxAdequate] = 16'($urandom_range(0, 2000));
      plan[p][nwdl_pkg::CfgLuxGood]     = 16'($urandom_range(0, 2000));
    end
    plan[1] = '{default: 16'h0000};
    plan[2] = '{default: 16'hFFFF};
    // good threshold below adequate
    plan[3] = '{16'd400, 16'd5, 16'd900, 16'd500, 16'd300};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (probes[i]) offer_sample(probes[i].smp, probes[i].pinned, probes[i].want);

    foreach (plan[p]) begin
      // thresholds only change with the block empty
      in_valid_i <= 1'b0;
      while (readings_due.size() != 0) @(negedge clk_i);
      foreach (reg_order[r]) write_reg(reg_order[r], plan[p][reg_order[r]]);
      cfg_valid_i <= 1'b0;
      repeat (PhaseItems) offer_sample(draft_sample());
    end
    in_valid_i <= 1'b0;

    while (readings_due.size() != 0) @(negedge clk_i);
    // anything late or extra shows up here
    repeat (DrainCycles) @(posedge clk_i);
    if (faults == 0) begin
      $display("near_work_dwell_and_light_monitor: match");
    end else begin
      $display("near_work_dwell_and_light_monitor: mismatch");
    end
    $finish;
  end

  // receiver ready, changed at the falling edge from the wait drawn per reading
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // readings are checked field by field against the oldest one owed
  initial begin
    nwdl_pkg::out_t got;
    nwdl_pkg::out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = out_o;
        if (readings_due.size() == 0) begin
          note_mismatch($sformatf("reading with none owed: %h", got));
        end else begin
          want = readings_due.pop_front();
          if (got.light_quality !== want.light_quality)
            note_mismatch($sformatf("light_quality got %0d want %0d",
                                    got.light_quality, want.light_quality));
          if (got.dose !== want.dose)
            note_mismatch($sformatf("dose got %0d want %0d", got.dose, want.dose));
          if (got.dose_percent !== want.dose_percent)
            note_mismatch($sformatf("dose_percent got %0d want %0d",
                                    got.dose_percent, want.dose_percent));
          if (got.near_active !== want.near_active)
            note_mismatch($sformatf("near_active got %0d want %0d",
                                    got.near_active, want.near_active));
          if (got.near_minutes !== want.near_minutes)
            note_mismatch($sformatf("near_minutes got %0d want %0d",
                                    got.near_minutes, want.near_minutes));
        end
        readings_taken++;
        // one long hold while the sender keeps pushing, so both stages fill
        rx_wait = (readings_taken == HoldAt) ? HoldCycles : draw_gap(calm_rx);
      end
    end
  end

  // watchdog on cycles with no request, reading or register write moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit) begin
        $display("near_work_dwell_and_light_monitor: mismatch");
        $finish;
      end
    end
  end

endmodule

/* files.f */
+incdir+sv
sv/nwdl_pkg.sv
sv/nwdl_out_stage.sv
sv/near_work_dwell_and_light_monitor.sv
sv/nwdl_checker.sv
tb/sv/tb_near_work_dwell_and_light_monitor.sv
